[hdl/cp1252tc_pkg.sv]
// ----------------------------------------------------------------------------
// cp1252tc_pkg
// Shared types, constants and mapping functions of the Windows-1252 / UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package cp1252tc_pkg;

   localparam logic DIR_ENC = 1'b0;   // windows-1252 to utf-8
   localparam logic DIR_DEC = 1'b1;   // utf-8 to windows-1252

   localparam logic [7:0]  QMARK      = 8'h3F;
   localparam logic [7:0]  NUL_MAP    = 8'h81;
   localparam logic [15:0] TWO_BYTE_MIN   = 16'h0080;
   localparam logic [15:0] THREE_BYTE_MIN = 16'h0800;

   localparam int JOB_SLOTS = 3;

   localparam logic [15:0] HIGH_TABLE [32] = '{
      16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
      16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
   };

   // one queued transaction: up to three code points and how many bytes they give
   typedef struct packed {
      logic                            dir;
      logic [JOB_SLOTS-1:0][15:0]      cps;
      logic [1:0]                      cnt;
      logic                            eos;
   } job_type;

   function automatic logic [15:0] byte_to_cp(input logic [7:0] b);
      logic [15:0] t;
      t = HIGH_TABLE[b[4:0]];
      if (b[7:5] == 3'b100 && t != 16'h0000) begin
         return t;
      end
      return {8'h00, b};
   endfunction

   function automatic logic [7:0] cp_to_byte(input logic [15:0] cp);
      logic [7:0] res;
      logic       hit;
      res = QMARK;
      hit = 1'b0;
      for (int i = 0; i < 32; i++) begin
         if (!hit && HIGH_TABLE[i] == cp) begin
            res = 8'h80 + 8'(i);
            hit = 1'b1;
         end
      end
      if ((cp != 16'h0000 && cp < 16'h0080) || (cp >= 16'h00A0 && cp <= 16'h00FF)) begin
         res = cp[7:0];
      end else if (cp inside {16'h0081, 16'h008D, 16'h008F, 16'h0090, 16'h009D}) begin
         res = cp[7:0];
      end else if (cp == 16'h0000) begin
         res = NUL_MAP;
      end
      return res;
   endfunction

   // byte idx of the utf-8 form of cp, which is cnt bytes long
   function automatic logic [7:0] utf8_byte(input logic [15:0] cp, input logic [1:0] cnt,
                                            input logic [1:0] idx);
      logic [7:0] res;
      case (cnt)
         2'd2: begin
            res = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         end
         2'd3: begin
            case (idx)
               2'd0:    res = {4'b1110, cp[15:12]};
               2'd1:    res = {2'b10, cp[11:6]};
               default: res = {2'b10, cp[5:0]};
            endcase
         end
         default: res = cp[7:0];
      endcase
      return res;
   endfunction

endpackage

[hdl/cp1252tc_front.sv]
// ----------------------------------------------------------------------------
// cp1252tc_front
// Accepts source bytes, holds the direction register and the pending utf-8
// sequence, and turns each byte into a job of code points for the back end.
// ----------------------------------------------------------------------------
module cp1252tc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic                  csr_data,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [7:0]            in_byte,
   input  logic                  in_eos,
   input  logic                  queue_full,
   output logic                  push,
   output cp1252tc_pkg::job_type push_job
);
   import cp1252tc_pkg::*;

   logic            direction_ff, direction_in;
   logic [1:0][7:0] pend_ff, pend_in;
   logic [1:0]      pcnt_ff, pcnt_in;

   logic            accept;
   logic [2:0][7:0] q;
   logic [1:0]      len;
   logic [1:0]      n;
   logic            go;
   logic [7:0]      b0;
   logic [1:0]      used;
   logic [15:0]     val;
   logic            hold;
   logic [JOB_SLOTS-1:0][15:0] dec_cps;
   logic [15:0]     enc_cp;
   logic [1:0]      enc_cnt;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   // utf-8 parse over pending bytes plus the new one, at most three results
   always_comb begin
      q       = '0;
      dec_cps = '0;
      n       = 2'd0;
      go      = 1'b1;
      b0      = 8'h00;
      used    = 2'd1;
      val     = {8'h00, QMARK};
      hold    = 1'b0;
      case (pcnt_ff)
         2'd0:    q = {16'h0000, in_byte};
         2'd1:    q = {8'h00, in_byte, pend_ff[0]};
         default: q = {in_byte, pend_ff[1], pend_ff[0]};
      endcase
      len = (pcnt_ff > 2'd2) ? 2'd3 : pcnt_ff + 2'd1;
      for (int k = 0; k < JOB_SLOTS; k++) begin
         if (go && len != 2'd0) begin
            b0   = q[0];
            used = 2'd1;
            val  = {8'h00, QMARK};
            hold = 1'b0;
            if (!b0[7]) begin
               val = {8'h00, b0};
            end else if (b0[7:5] == 3'b110) begin
               if (len >= 2'd2) begin
                  if (q[1][7:6] == 2'b10) begin
                     val  = {5'd0, b0[4:0], q[1][5:0]};
                     used = 2'd2;
                  end
               end else if (!in_eos) begin
                  hold = 1'b1;
               end
            end else if (b0[7:4] == 4'b1110) begin
               if (len >= 2'd2 && q[1][7:6] != 2'b10) begin
                  // bad lead, emit '?' for it alone
                  val = {8'h00, QMARK};
               end else if (len == 2'd3) begin
                  if (q[2][7:6] == 2'b10) begin
                     val  = {b0[3:0], q[1][5:0], q[2][5:0]};
                     used = 2'd3;
                  end
               end else if (!in_eos) begin
                  hold = 1'b1;
               end
            end
            if (hold) begin
               go = 1'b0;
            end else begin
               dec_cps[n] = val;
               n = n + 2'd1;
               case (used)
                  2'd1:    q = {8'h00, q[2], q[1]};
                  2'd2:    q = {16'h0000, q[2]};
                  default: q = '0;
               endcase
               len = len - used;
            end
         end
      end
   end

   always_comb begin
      enc_cp = byte_to_cp(in_byte);
      if (enc_cp < TWO_BYTE_MIN) begin
         enc_cnt = 2'd1;
      end else if (enc_cp < THREE_BYTE_MIN) begin
         enc_cnt = 2'd2;
      end else begin
         enc_cnt = 2'd3;
      end
   end

   always_comb begin
      push_job.dir = direction_ff;
      push_job.eos = in_eos;
      if (direction_ff == DIR_DEC) begin
         push_job.cps = dec_cps;
         push_job.cnt = n;
      end else begin
         push_job.cps = {32'h0, enc_cp};
         push_job.cnt = enc_cnt;
      end
   end

   // a waiting step only extends the pending sequence and queues nothing
   assign push = accept && push_job.cnt != 2'd0;

   always_comb begin
      direction_in = direction_ff;
      pend_in      = pend_ff;
      pcnt_in      = pcnt_ff;
      if (csr_valid) begin
         direction_in = csr_data;
         pend_in      = '0;
         pcnt_in      = 2'd0;
      end else if (accept && direction_ff == DIR_DEC) begin
         pend_in = {q[1], q[0]};
         pcnt_in = len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_ENC;
         pend_ff      <= '0;
         pcnt_ff      <= 2'd0;
      end else begin
         direction_ff <= direction_in;
         pend_ff      <= pend_in;
         pcnt_ff      <= pcnt_in;
      end
   end

endmodule

[hdl/cp1252tc_queue.sv]
// ----------------------------------------------------------------------------
// cp1252tc_queue
// Small job queue between the front and back ends.
// ----------------------------------------------------------------------------
module cp1252tc_queue #(
   parameter int DEPTH = 4   // two or more
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cp1252tc_pkg::job_type push_job,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output cp1252tc_pkg::job_type head_job
);
   import cp1252tc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/cp1252tc_back.sv]
// ----------------------------------------------------------------------------
// cp1252tc_back
// Walks the head job one output byte per cycle, unless rsp stalls, into the result register:
// utf-8 byte forming when encoding, reverse table mapping when decoding.
// ----------------------------------------------------------------------------
module cp1252tc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  cp1252tc_pkg::job_type head_job,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);
   import cp1252tc_pkg::*;

   logic        valid_ff, valid_in;
   logic [7:0]  data_ff, data_in;
   logic        run_ff, run_in;
   logic        str_ff, str_in;
   logic [1:0]  idx_ff, idx_in;
   logic        load, take, last;
   logic [15:0] sel_cp;

   assign load = !valid_ff || rsp_tready;
   assign take = load && head_valid;
   assign last = (idx_ff == head_job.cnt - 2'd1);
   assign pop  = take && last;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_cp = head_job.cps[0];
         2'd1:    sel_cp = head_job.cps[1];
         default: sel_cp = head_job.cps[2];
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      run_in   = run_ff;
      str_in   = str_ff;
      if (take) begin
         idx_in   = last ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
         data_in  = (head_job.dir == DIR_DEC) ? cp_to_byte(sel_cp)
                                              : utf8_byte(head_job.cps[0], head_job.cnt, idx_ff);
         run_in   = last;
         str_in   = last && head_job.eos;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      run_ff  <= run_in;
      str_ff  <= str_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = run_ff;
   assign rsp_tlast  = str_ff;

endmodule

[hdl/cp1252_utf8_transcoder.sv]
// ----------------------------------------------------------------------------
// cp1252_utf8_transcoder
// Streaming Windows-1252 / UTF-8 byte transcoder, top level.
// ----------------------------------------------------------------------------
// Usage:
//   csr port writes the direction bit (0 encodes windows-1252 to utf-8,
//   1 decodes utf-8 to windows-1252); a write also drops any pending partial
//   utf-8 sequence. csr_ready is always high; write only while idle.
//   req stream carries source bytes, tlast on the final byte of a string.
//   rsp stream carries converted bytes; tuser marks the last byte produced
//   by one req transaction, tlast the final byte of the string.
// Timing:
//   a req transaction is classified in the cycle it is accepted and queued;
//   its rsp bytes come from the job queue through the output register.
//   the back end emits one rsp byte per cycle while rsp is not stalled; an
//   item produces one to three bytes (none when a byte only extends a
//   pending sequence); req is accepted every cycle while the job queue has
//   room.
// Reset clears the direction to encode, the pending sequence, the queue and
// the output valid flag. When rsp stalls the output byte holds and the queue
// fills, after which req_tready drops.
// ----------------------------------------------------------------------------
module cp1252_utf8_transcoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data,     // direction
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // data_byte
   input  logic       req_tlast,    // end_of_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // out_byte
   output logic       rsp_tuser,    // last_of_run
   output logic       rsp_tlast     // last_of_string
);
   import cp1252tc_pkg::*;

   logic    push, full, pop, head_valid;
   job_type push_job, head_job;

   assign csr_ready = 1'b1;

   cp1252tc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_eos     (req_tlast),
      .queue_full (full),
      .push       (push),
      .push_job   (push_job)
   );

   cp1252tc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   cp1252tc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[hdl/cp1252tc_checker.sv]
// ----------------------------------------------------------------------------
// cp1252tc_checker
// Port level checks of the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
module cp1252tc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // nothing comes out of the output register right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // the empty queue takes a transaction right after reset
   a_reset_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("req_tready low after reset");

   // end of string is always also the end of that transaction's run
   a_last_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("rsp_tlast without rsp_tuser");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

endmodule

bind cp1252_utf8_transcoder cp1252tc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[sim/transcode_checker.sv]
// ----------------------------------------------------------------------------
// transcode_checker
// Watches the csr, req and rsp channels of the Windows-1252 / UTF-8
// transcoder, predicts every output byte from the accepted source bytes and
// compares each rsp transaction in order against the oldest prediction.
// ----------------------------------------------------------------------------
module transcode_checker
   import cp1252tc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic       csr_data,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tuser,
   input  logic       rsp_tlast,
   output int         fail_count,
   output int         results_left,
   output int         results_checked
);

   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_NUL_SUB  = 8'h81;

   localparam logic [15:0] WIN_HIGH_CP [32] = '{
      16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
      16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
   };

   typedef struct packed {
      logic [7:0] data;
      logic       run_end;
      logic       str_end;
   } out_byte_t;

   out_byte_t  expected_bytes [$];
   logic       direction;
   logic [7:0] held_bytes [2];
   int         held_count;
   int         mismatches;
   int         checked;

   function automatic logic [15:0] win_to_cp(input logic [7:0] b);
      logic [15:0] t;
      t = WIN_HIGH_CP[b[4:0]];
      if (b >= 8'h80 && b < 8'hA0 && t != 16'h0000) begin
         return t;
      end
      return {8'h00, b};
   endfunction

   function automatic logic [7:0] cp_to_win(input logic [15:0] cp);
      logic [7:0] res;
      logic       found;
      res = CH_QUESTION;
      found = 1'b0;
      if ((cp != 16'h0000 && cp < 16'h0080) || (cp >= 16'h00A0 && cp <= 16'h00FF)) begin
         res = cp[7:0];
      end else if (cp == 16'h0081 || cp == 16'h008D || cp == 16'h008F ||
                   cp == 16'h0090 || cp == 16'h009D) begin
         res = cp[7:0];
      end else if (cp == 16'h0000) begin
         res = CH_NUL_SUB;
      end else begin
         for (int i = 0; i < 32; i++) begin
            if (!found && WIN_HIGH_CP[i] == cp) begin
               res = 8'h80 + 8'(i);
               found = 1'b1;
            end
         end
      end
      return res;
   endfunction

   function automatic logic is_cont(input logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

   // works out the output bytes of one source byte and queues them
   task automatic transcode_byte(input logic [7:0] b, input logic eos);
      logic [7:0]  res [3];
      logic [7:0]  q [3];
      logic [7:0]  b0;
      logic [7:0]  v;
      logic [15:0] cp;
      logic        hold;
      int          n;
      int          len;
      int          used;
      out_byte_t   ob;
      n = 0;
      if (direction == DIR_ENC) begin
         cp = win_to_cp(b);
         if (cp < 16'h0080) begin
            res[0] = cp[7:0];
            n = 1;
         end else if (cp < 16'h0800) begin
            res[0] = {3'b110, cp[10:6]};
            res[1] = {2'b10, cp[5:0]};
            n = 2;
         end else begin
            res[0] = {4'b1110, cp[15:12]};
            res[1] = {2'b10, cp[11:6]};
            res[2] = {2'b10, cp[5:0]};
            n = 3;
         end
      end else begin
         len = 0;
         for (int i = 0; i < held_count; i++) begin
            q[len] = held_bytes[i];
            len++;
         end
         q[len] = b;
         len++;
         hold = 1'b0;
         while (len > 0 && !hold) begin
            b0 = q[0];
            used = 1;
            v = CH_QUESTION;
            if (b0 < 8'h80) begin
               v = cp_to_win({8'h00, b0});
            end else if (b0[7:5] == 3'b110) begin
               if (len >= 2) begin
                  if (is_cont(q[1])) begin
                     v = cp_to_win({5'b00000, b0[4:0], q[1][5:0]});
                     used = 2;
                  end
               end else if (!eos) begin
                  hold = 1'b1;
               end
            end else if (b0[7:4] == 4'b1110) begin
               // a lead followed by a non-continuation is bad right away
               if (len == 1 || is_cont(q[1])) begin
                  if (len >= 3) begin
                     if (is_cont(q[2])) begin
                        v = cp_to_win({b0[3:0], q[1][5:0], q[2][5:0]});
                        used = 3;
                     end
                  end else if (!eos) begin
                     hold = 1'b1;
                  end
               end
            end
            if (!hold) begin
               res[n] = v;
               n++;
               for (int i = 0; i + used < len; i++) begin
                  q[i] = q[i + used];
               end
               len -= used;
            end
         end
         held_bytes[0] = (len > 0) ? q[0] : 8'h00;
         held_bytes[1] = (len > 1) ? q[1] : 8'h00;
         held_count = len;
      end
      for (int i = 0; i < n; i++) begin
         ob.data    = res[i];
         ob.run_end = (i == n - 1);
         ob.str_end = (i == n - 1) && eos;
         expected_bytes.push_back(ob);
      end
   endtask

   task automatic note_failure(input string what, input out_byte_t want,
                               input logic [7:0] d, input logic u, input logic l);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch (%s): expected byte %02h run_end %b str_end %b, got %02h %b %b",
                  what, want.data, want.run_end, want.str_end, d, u, l);
      end
   endtask

   always @(posedge clock) begin
      out_byte_t want;
      if (reset) begin
         direction = DIR_ENC;
         held_bytes[0] = 8'h00;
         held_bytes[1] = 8'h00;
         held_count = 0;
         expected_bytes.delete();
         mismatches = 0;
         checked = 0;
      end else begin
         // compare first: a byte leaving now never belongs to a source byte entering now
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               want = '0;
               note_failure("no byte expected", want, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = expected_bytes.pop_front();
               checked++;
               if (rsp_tdata !== want.data || rsp_tuser !== want.run_end ||
                   rsp_tlast !== want.str_end) begin
                  note_failure("wrong field", want, rsp_tdata, rsp_tuser, rsp_tlast);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            direction = csr_data;
            held_bytes[0] = 8'h00;
            held_bytes[1] = 8'h00;
            held_count = 0;
         end
         if (req_tvalid && req_tready) begin
            transcode_byte(req_tdata, req_tlast);
         end
      end
      fail_count      <= mismatches;
      results_left    <= expected_bytes.size();
      results_checked <= checked;
   end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Top of the transcoder simulation: drives directed and random source bytes
// in both directions with bursty input and a stalling output, switches the
// direction between phases while idle, and reports the verdict from the
// checker.
// ----------------------------------------------------------------------------
module testbench;
   import cp1252tc_pkg::*;

   typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_PATTERN, RX_COIN} rx_mode_e;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       csr_valid  = 1'b0;
   logic       csr_data   = DIR_ENC;
   logic       req_tvalid = 1'b0;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tready = 1'b0;
   logic       csr_ready;
   logic       req_tready;
   logic       rsp_tvalid;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;

   int fail_count;
   int results_left;
   int results_checked;
   int burst_left = 0;
   int bytes_sent = 0;
   int phases     = 0;

   rx_mode_e   rx_mode   = RX_ALWAYS;
   int         rx_ticks  = 0;
   logic [7:0] rx_stalls = 8'b1011_0110;

   always #2 clock = ~clock;

   cp1252_utf8_transcoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   transcode_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .fail_count      (fail_count),
      .results_left    (results_left),
      .results_checked (results_checked)
   );

   // receiver picks a new random stall behavior whenever its tick counter runs out
   always @(posedge clock) begin
      if (rx_ticks == 0) begin
         rx_mode   <= rx_mode_e'($urandom_range(0, 3));
         rx_stalls <= 8'($urandom) | 8'h01;
         rx_ticks  <= $urandom_range(16, 80);
      end else begin
         rx_ticks <= rx_ticks - 1;
      end
      case (rx_mode)
         RX_ALWAYS:  rsp_tready <= 1'b1;
         RX_MOSTLY:  rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_PATTERN: rsp_tready <= rx_stalls[rx_ticks % 8];
         default:    rsp_tready <= 1'($urandom_range(0, 1));
      endcase
   end

   // sends one source byte, opening a new burst after a random gap when due
   task automatic send_byte(input logic [7:0] d, input logic l);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   function automatic logic pick_last();
      return $urandom_range(0, 11) == 0;
   endfunction

   // holds the input off until every predicted byte is out, then lets the
   // back end settle in case the last source byte only extended a sequence
   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_left != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_direction(input logic d);
      csr_valid <= 1'b1;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // utf-8 form of cp in nb bytes, overlong forms included
   task automatic send_utf8(input logic [15:0] cp, input int nb);
      if (nb == 1) begin
         send_byte({1'b0, cp[6:0]}, pick_last());
      end else if (nb == 2) begin
         send_byte({3'b110, cp[10:6]}, pick_last());
         send_byte({2'b10, cp[5:0]}, pick_last());
      end else begin
         send_byte({4'b1110, cp[15:12]}, pick_last());
         send_byte({2'b10, cp[11:6]}, pick_last());
         send_byte({2'b10, cp[5:0]}, pick_last());
      end
   endtask

   task automatic encode_phase(input int count);
      logic [7:0] b;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 2) == 0) begin
            b = 8'h80 + 8'($urandom_range(0, 31));
         end else begin
            b = 8'($urandom_range(0, 255));
         end
         send_byte(b, pick_last());
      end
   endtask

   // mostly well-formed characters with random content, some noise and breakage
   task automatic decode_phase(input int count);
      int          start;
      logic [15:0] cp;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2: send_utf8(16'($urandom_range(0, 127)), 1);
            3:       send_utf8(16'($urandom_range(16'h80, 16'hFF)), 2);
            4:       send_utf8(16'($urandom_range(0, 16'h7FF)), 2);
            5: begin
               case ($urandom_range(0, 6))
                  0:       cp = 16'h20AC;
                  1:       cp = 16'h2122;
                  2:       cp = 16'h0178;
                  3:       cp = 16'h2013;
                  4:       cp = 16'h201D;
                  5:       cp = 16'h02DC;
                  default: cp = 16'h2039;
               endcase
               send_utf8(cp, 3);
            end
            6:       send_utf8(16'($urandom_range(0, 16'hFFFF)), 3);
            7:       send_byte(8'($urandom_range(0, 255)), pick_last());
            8: begin
               // lead cut short by a plain character
               if ($urandom_range(0, 1) == 0) begin
                  send_byte(8'($urandom_range(8'hC0, 8'hDF)), pick_last());
               end else begin
                  send_byte(8'($urandom_range(8'hE0, 8'hEF)), pick_last());
                  if ($urandom_range(0, 1) == 0) begin
                     send_byte(8'($urandom_range(8'h80, 8'hBF)), pick_last());
                  end
               end
               send_byte(8'($urandom_range(0, 127)), pick_last());
            end
            default: begin
               if ($urandom_range(0, 1) == 0) begin
                  send_byte(8'($urandom_range(8'hF0, 8'hFF)), pick_last());
               end else begin
                  send_byte(8'($urandom_range(8'h80, 8'hBF)), pick_last());
               end
            end
         endcase
      end
   endtask

   initial begin
      logic phase_dir;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // encode extremes: ascii ends, euro, undefined slot, two and three byte forms
      write_direction(DIR_ENC);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h81, 1'b0);
      send_byte(8'h8A, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'hA0, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain_and_settle();

      // decode: two and three byte forms, null code point, short sequence at
      // end of string, four-byte lead, stray continuation, malformed leads,
      // code point with no windows-1252 byte
      write_direction(DIR_DEC);
      send_byte(8'h41, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'hA9, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      send_byte(8'hC0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h80, 1'b1);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hE4, 1'b0);
      send_byte(8'hB8, 1'b0);
      send_byte(8'h80, 1'b1);
      drain_and_settle();

      for (int p = 0; p < 7; p++) begin
         phase_dir = (p == 0 || p == 3 || p == 5) ? DIR_ENC : DIR_DEC;
         write_direction(phase_dir);
         if (phase_dir == DIR_ENC) begin
            encode_phase($urandom_range(40, 50));
         end else begin
            decode_phase($urandom_range(40, 50));
         end
         drain_and_settle();
         phases++;
      end
      repeat (8) @(posedge clock);

      $display("sent %0d source bytes over %0d random phases in both directions",
               bytes_sent, phases);
      $display("checked %0d output bytes, %0d failures", results_checked, fail_count);
      if (fail_count == 0 && results_left == 0) begin
         $display("PASS cp1252_utf8_transcoder");
      end else begin
         $display("FAIL cp1252_utf8_transcoder");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL cp1252_utf8_transcoder");
      $finish;
   end

endmodule
